FILE: design/bgpe_pkg.sv
// ----------------------------------------------------------------------------
// Bitsliced gate program executor package
// Field widths, command and gate codes, and the control and status structs
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bgpe_pkg;

    localparam int CMD_W   = 2;
    localparam int OP_W    = 8;
    localparam int ADDR_W  = 12;
    localparam int DATA_W  = 64;
    localparam int ADDR_SPAN = 1 << ADDR_W;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GATE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [OP_W-1:0] OP_XOR  = 8'd1;
    localparam logic [OP_W-1:0] OP_AND  = 8'd2;
    localparam logic [OP_W-1:0] OP_OR   = 8'd3;
    localparam logic [OP_W-1:0] OP_NOT  = 8'd4;
    localparam logic [OP_W-1:0] OP_ZERO = 8'd5;

    typedef struct packed {
        logic capture;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_sts;

endpackage

FILE: design/bgpe_ctrl.sv
// ----------------------------------------------------------------------------
// Bitsliced gate program executor controller
// Two-state sequencer: takes a word in idle, then finishes it once the
// output register is free.
// ----------------------------------------------------------------------------
module bgpe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_stall,
    input  bgpe_pkg::t_dp_sts  i_sts,
    output bgpe_pkg::t_ctrl_cmd o_cmd
);
    import bgpe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   finish;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign finish  = (r_state == S_EXEC) && (!i_sts.out_valid || !i_stall);
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (finish) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.capture = accept;
        o_cmd.finish  = finish;
    end

endmodule

FILE: design/bgpe_datapath.sv
// ----------------------------------------------------------------------------
// Bitsliced gate program executor datapath
// Word RAM with two read ports and one write port, the gate unit, the halt
// flag and the output register.
// ----------------------------------------------------------------------------
module bgpe_datapath #(
    parameter int RAM_WORDS = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bgpe_pkg::t_ctrl_cmd          i_cmd,
    output bgpe_pkg::t_dp_sts            o_sts,
    input  logic [bgpe_pkg::CMD_W-1:0]   i_command,
    input  logic [bgpe_pkg::OP_W-1:0]    i_op_code,
    input  logic [bgpe_pkg::ADDR_W-1:0]  i_dst_addr,
    input  logic [bgpe_pkg::ADDR_W-1:0]  i_src_a,
    input  logic [bgpe_pkg::ADDR_W-1:0]  i_src_b,
    input  logic [bgpe_pkg::DATA_W-1:0]  i_write_data,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [bgpe_pkg::DATA_W-1:0]  o_read_data,
    output logic                         o_halted
);
    import bgpe_pkg::*;

    localparam int IDX_W = $clog2(RAM_WORDS);
    localparam int RED_STEPS = (RAM_WORDS >= ADDR_SPAN) ? 0 : $clog2(ADDR_SPAN / RAM_WORDS);
    localparam logic [ADDR_W+1:0] MOD_C = (ADDR_W+2)'(RAM_WORDS);

    // Addresses wrap at the RAM depth by a short chain of compare and subtract.
    function automatic logic [IDX_W-1:0] f_index(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+1:0] r;
        r = {2'b00, addr};
        if (RAM_WORDS < ADDR_SPAN) begin
            for (int k = RED_STEPS; k >= 0; k--) begin
                if (r >= (MOD_C << k)) r = r - (MOD_C << k);
            end
        end
        return IDX_W'(r);
    endfunction

    logic [WORD_BITS-1:0] r_mem [RAM_WORDS];
    logic [WORD_BITS-1:0] r_rd_a;
    logic [WORD_BITS-1:0] r_rd_b;
    logic [WORD_BITS-1:0] r_wdata;
    logic [CMD_W-1:0]     r_cmd;
    logic [OP_W-1:0]      r_op;
    logic [IDX_W-1:0]     r_dst;
    logic                 r_halt;
    logic                 n_halt;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;
    logic                 r_out_halted;

    logic [IDX_W-1:0]     rd_idx_a;
    logic [IDX_W-1:0]     rd_idx_b;
    logic                 op_ok;
    logic                 gate_run;
    logic [WORD_BITS-1:0] gate_res;
    logic                 w_en;
    logic [WORD_BITS-1:0] w_data;
    logic [DATA_W-1:0]    out_data;

    assign rd_idx_a = f_index((i_command == CMD_READ) ? i_dst_addr : i_src_a);
    assign rd_idx_b = f_index(i_src_b);

    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[r_dst] <= w_data;
        if (i_cmd.capture) begin
            r_rd_a  <= r_mem[rd_idx_a];
            r_rd_b  <= r_mem[rd_idx_b];
            r_wdata <= i_write_data[WORD_BITS-1:0];
            r_cmd   <= i_command;
            r_op    <= i_op_code;
            r_dst   <= f_index(i_dst_addr);
        end
    end

    always_comb begin
        op_ok    = 1'b1;
        gate_res = '0;
        unique case (r_op)
            OP_XOR:  gate_res = r_rd_a ^ r_rd_b;
            OP_AND:  gate_res = r_rd_a & r_rd_b;
            OP_OR:   gate_res = r_rd_a | r_rd_b;
            OP_NOT:  gate_res = ~r_rd_a;
            OP_ZERO: gate_res = '0;
            default: op_ok = 1'b0;
        endcase
    end

    assign gate_run = (r_cmd == CMD_GATE) && !r_halt;

    always_comb begin
        n_halt   = r_halt;
        w_en     = 1'b0;
        w_data   = r_wdata;
        out_data = '0;
        unique case (r_cmd)
            CMD_START: n_halt = 1'b0;
            CMD_WRITE: w_en = i_cmd.finish;
            CMD_GATE: begin
                if (gate_run) begin
                    if (op_ok) begin
                        w_en   = i_cmd.finish;
                        w_data = gate_res;
                    end else begin
                        n_halt = 1'b1;
                    end
                end
            end
            CMD_READ: out_data = DATA_W'(r_rd_a);
            default: n_halt = r_halt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_halted <= 1'b0;
        end else if (i_cmd.finish) begin
            r_halt       <= n_halt;
            r_out_valid  <= 1'b1;
            r_out_halted <= n_halt;
        end else if (!i_stall) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) r_out_data <= out_data;
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_valid         = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_halted        = r_out_halted;

endmodule

FILE: design/bitsliced_gate_program_executor_core.sv
// ----------------------------------------------------------------------------
// Bitsliced gate program executor core
// Runs a gate program over a RAM of bitsliced words, one command per word.
//
//   channel   direction  handshake          payload
//   command   in         i_valid / o_stall  command, op_code, dst_addr,
//                                           src_a, src_b, write_data
//   result    out        o_valid / i_stall  read_data, halted
//
// Each command reads both RAM ports into registers as it is taken in idle;
// the exec state then applies the gate, writes the RAM and loads the output
// register, waiting while that register is full and stalled. The command port is stalled in exec.
// Reset clears the halt flag and the output valid; the RAM is not cleared.
// ----------------------------------------------------------------------------
module bitsliced_gate_program_executor_core #(
    parameter int RAM_WORDS = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bgpe_pkg::CMD_W-1:0]   i_command,
    input  logic [bgpe_pkg::OP_W-1:0]    i_op_code,
    input  logic [bgpe_pkg::ADDR_W-1:0]  i_dst_addr,
    input  logic [bgpe_pkg::ADDR_W-1:0]  i_src_a,
    input  logic [bgpe_pkg::ADDR_W-1:0]  i_src_b,
    input  logic [bgpe_pkg::DATA_W-1:0]  i_write_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bgpe_pkg::DATA_W-1:0]  o_read_data,
    output logic                         o_halted
);
    import bgpe_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_sts   dp_sts;

    bgpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .i_sts   (dp_sts),
        .o_cmd   (ctrl_cmd)
    );

    bgpe_datapath #(
        .RAM_WORDS (RAM_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctrl_cmd),
        .o_sts        (dp_sts),
        .i_command    (i_command),
        .i_op_code    (i_op_code),
        .i_dst_addr   (i_dst_addr),
        .i_src_a      (i_src_a),
        .i_src_b      (i_src_b),
        .i_write_data (i_write_data),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_halted     (o_halted)
    );

endmodule

FILE: design/bgpe_checker.sv
// ----------------------------------------------------------------------------
// Bitsliced gate program executor checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
module bgpe_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [bgpe_pkg::DATA_W-1:0]  o_read_data,
    input logic                         o_halted
);
    import bgpe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_valid && i_stall |=> o_valid && $stable(o_read_data) && $stable(o_halted))
        else $error("Stalled result word changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_valid && !o_stall |=> o_stall)
        else $error("Command port was not stalled after a word was taken.");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid was set after reset.");

    a_halt_moves_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && $past(i_rst_n) && ($rose(o_halted) || $fell(o_halted)) |-> o_valid)
        else $error("Halt flag changed without a new result word.");

endmodule

bind bitsliced_gate_program_executor_core bgpe_checker u_bgpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_read_data (o_read_data),
    .o_halted    (o_halted)
);

FILE: tb/tb_bitsliced_gate_program_executor_core.sv
// ----------------------------------------------------------------------------
// Bitsliced gate program executor core testbench
// Sends a directed gate program and then a long random one. The random program
// reads only words that have already been written, and it halts and restarts
// along the way. The sender works in bursts and the receiver stalls in
// changing patterns. Each result word is checked against a predictor that
// keeps its own copy of the word RAM and of the halt flag.
// ----------------------------------------------------------------------------
module tb_bitsliced_gate_program_executor_core;
    import bgpe_pkg::*;

    localparam int RANDOM_WORDS   = 1700;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [OP_W-1:0]   op_code;
        logic [ADDR_W-1:0] dst_addr;
        logic [ADDR_W-1:0] src_a;
        logic [ADDR_W-1:0] src_b;
        logic [DATA_W-1:0] write_data;
    } t_cmd_word;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              halted;
    } t_result_word;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command    = '0;
    logic [OP_W-1:0]   i_op_code    = '0;
    logic [ADDR_W-1:0] i_dst_addr   = '0;
    logic [ADDR_W-1:0] i_src_a      = '0;
    logic [ADDR_W-1:0] i_src_b      = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic              o_halted;

    t_cmd_word         program_words[$];
    t_result_word      expected_results[$];

    logic [DATA_W-1:0] slice_ram [ADDR_SPAN];
    logic              halt_state = 1'b0;

    bit                gen_written [ADDR_SPAN];
    logic [ADDR_W-1:0] gen_written_list[$];
    bit                gen_halted = 1'b0;

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_cycle    = 0;
    int stall_mode     = 0;

    bitsliced_gate_program_executor_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_op_code    (i_op_code),
        .i_dst_addr   (i_dst_addr),
        .i_src_a      (i_src_a),
        .i_src_b      (i_src_b),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_halted     (o_halted)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result_word execute_command(t_cmd_word w);
        t_result_word      r;
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] vb;
        r.read_data = '0;
        va = slice_ram[w.src_a];
        vb = slice_ram[w.src_b];
        case (w.command)
            CMD_START: begin
                halt_state = 1'b0;
            end
            CMD_WRITE: begin
                slice_ram[w.dst_addr] = w.write_data;
            end
            CMD_GATE: begin
                if (!halt_state) begin
                    case (w.op_code)
                        OP_XOR:  slice_ram[w.dst_addr] = va ^ vb;
                        OP_AND:  slice_ram[w.dst_addr] = va & vb;
                        OP_OR:   slice_ram[w.dst_addr] = va | vb;
                        OP_NOT:  slice_ram[w.dst_addr] = ~va;
                        OP_ZERO: slice_ram[w.dst_addr] = '0;
                        default: halt_state = 1'b1;
                    endcase
                end
            end
            default: begin
                r.read_data = slice_ram[w.dst_addr];
            end
        endcase
        r.halted = halt_state;
        return r;
    endfunction

    function automatic void mark_written(logic [ADDR_W-1:0] addr);
        if (!gen_written[addr]) begin
            gen_written[addr] = 1'b1;
            gen_written_list.push_back(addr);
        end
    endfunction

    function automatic logic [ADDR_W-1:0] any_written();
        if (gen_written_list.size() == 0) begin
            return ADDR_W'($urandom_range(0, ADDR_SPAN - 1));
        end
        return gen_written_list[$urandom_range(0, gen_written_list.size() - 1)];
    endfunction

    function automatic logic [DATA_W-1:0] any_data();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [OP_W-1:0] bad_op();
        int r;
        r = $urandom_range(0, 250);
        return (r == 0) ? OP_W'(0) : OP_W'(r + 5);
    endfunction

    // The generator tracks which words hold data so that no gate source and no
    // read ever touches a word that was never written.
    task automatic queue_word(logic [CMD_W-1:0] cmd, logic [OP_W-1:0] op,
                              logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] a,
                              logic [ADDR_W-1:0] b, logic [DATA_W-1:0] data);
        program_words.push_back('{cmd, op, dst, a, b, data});
        case (cmd)
            CMD_START: gen_halted = 1'b0;
            CMD_WRITE: mark_written(dst);
            CMD_GATE: begin
                if (!gen_halted) begin
                    if (op >= OP_XOR && op <= OP_ZERO) begin
                        mark_written(dst);
                    end else begin
                        gen_halted = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : drive_proc
        t_cmd_word w;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(execute_command('{i_command, i_op_code,
                    i_dst_addr, i_src_a, i_src_b, i_write_data}));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0 || program_words.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    i_valid <= 1'b0;
                end else begin
                    w = program_words.pop_front();
                    i_command    <= w.command;
                    i_op_code    <= w.op_code;
                    i_dst_addr   <= w.dst_addr;
                    i_src_a      <= w.src_a;
                    i_src_b      <= w.src_b;
                    i_write_data <= w.write_data;
                    i_valid      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor_proc
        t_result_word seen;
        t_result_word want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                seen = '{o_read_data, o_halted};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result word: read_data %h halted %b",
                                 seen.read_data, seen.halted);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (seen.read_data !== want.read_data || seen.halted !== want.halted) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: read_data exp %h got %h, halted exp %b got %b",
                                     want.read_data, seen.read_data, want.halted, seen.halted);
                        end
                    end
                end
            end
            stall_cycle++;
            if (stall_cycle % 256 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 9) < 3);
                2:       i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= ((stall_cycle % 8) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int r;
        logic [OP_W-1:0] op;

        // Directed program: data extremes, every gate, aliasing, back-to-back
        // dependence, halting, and work done while halted.
        queue_word(CMD_WRITE, OP_XOR, 12'h000, 12'h000, 12'h000, '0);
        queue_word(CMD_WRITE, OP_XOR, 12'hFFF, 12'h000, 12'h000, '1);
        queue_word(CMD_WRITE, OP_XOR, 12'hAAA, 12'h000, 12'hFFF, {32{2'b10}});
        queue_word(CMD_WRITE, OP_XOR, 12'h555, 12'hFFF, 12'h000, {32{2'b01}});
        queue_word(CMD_READ, OP_XOR, 12'hFFF, 12'hAAA, 12'h555, '0);
        queue_word(CMD_GATE, OP_XOR, 12'h123, 12'hAAA, 12'h555, '1);
        queue_word(CMD_GATE, OP_AND, 12'h124, 12'hAAA, 12'hFFF, '0);
        queue_word(CMD_GATE, OP_OR, 12'h125, 12'h000, 12'h555, '0);
        queue_word(CMD_GATE, OP_NOT, 12'h126, 12'hAAA, 12'h555, '0);
        queue_word(CMD_GATE, OP_ZERO, 12'hFFF, 12'h126, 12'h000, '1);
        queue_word(CMD_GATE, OP_OR, 12'h127, 12'hFFF, 12'h123, '0);
        queue_word(CMD_GATE, OP_NOT, 12'h126, 12'h126, 12'h126, '0);
        queue_word(CMD_READ, OP_XOR, 12'h126, 12'h000, 12'h000, '1);
        queue_word(CMD_READ, OP_XOR, 12'h127, 12'h000, 12'h000, '0);
        queue_word(CMD_GATE, OP_W'(0), 12'h200, 12'h123, 12'h124, '0);
        queue_word(CMD_GATE, OP_XOR, 12'h201, 12'h123, 12'h124, '0);
        queue_word(CMD_GATE, OP_W'(255), 12'h202, 12'h125, 12'h126, '0);
        queue_word(CMD_WRITE, OP_XOR, 12'h200, 12'h000, 12'h000, {$urandom, $urandom});
        queue_word(CMD_READ, OP_XOR, 12'h200, 12'h000, 12'h000, '0);
        queue_word(CMD_START, OP_XOR, 12'h000, 12'h000, 12'h000, '0);
        queue_word(CMD_GATE, OP_W'(6), 12'h203, 12'h200, 12'h123, '0);
        queue_word(CMD_START, OP_W'(255), 12'hFFF, 12'hFFF, 12'hFFF, '1);
        queue_word(CMD_GATE, OP_XOR, 12'h000, 12'h200, 12'h200, '0);
        queue_word(CMD_READ, OP_XOR, 12'h000, 12'h000, 12'h000, '0);
        queue_word(CMD_READ, OP_XOR, 12'h123, 12'h000, 12'h000, '0);

        // Random program: mostly gates over words that hold data.
        repeat (RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (gen_halted ? (r < 40) : (r < 3)) begin
                queue_word(CMD_START, OP_W'($urandom), any_written(), any_written(),
                           any_written(), any_data());
            end else if (r < 25 || gen_written_list.size() < 4) begin
                queue_word(CMD_WRITE, OP_W'($urandom), ADDR_W'($urandom_range(0, ADDR_SPAN - 1)),
                           any_written(), any_written(), any_data());
            end else if (r < 80) begin
                op = ($urandom_range(0, 9) == 0) ? bad_op() : OP_W'($urandom_range(1, 5));
                queue_word(CMD_GATE, op,
                           ($urandom_range(0, 2) == 0) ? ADDR_W'($urandom_range(0, ADDR_SPAN - 1))
                                                       : any_written(),
                           any_written(), any_written(), any_data());
            end else begin
                queue_word(CMD_READ, OP_W'($urandom), any_written(), any_written(),
                           any_written(), any_data());
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (program_words.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
